// ===== rtl/spfa_pkg.sv =====
// ----------------------------------------------------------------------------
// spfa_pkg
// Shared constants, codes and the per-node record of the shortest path engine.
// ----------------------------------------------------------------------------
package spfa_pkg;

    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_MAX_EDGES = 16384;

    localparam int NODE_W   = 10;
    localparam int WEIGHT_W = 32;
    localparam int DIST_W   = 42;
    localparam int COUNT_W  = 11;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_SOLVE = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NEG_CYCLE = 2'd1;
    localparam logic [1:0] ST_UNREACH   = 2'd2;

    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 11'd1024;

    localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    // Per-node record held in the node memory.
    typedef struct packed {
        logic [COUNT_W-1:0] cnt;
        logic               inq;
        logic               reached;
        logic [DIST_W-1:0]  path_len;
    } node_t;

endpackage

// ===== rtl/spfa_shortest_path_neg_cycle.sv =====
// ----------------------------------------------------------------------------
// spfa_shortest_path_neg_cycle
// Queue-driven Bellman-Ford shortest path solver with negative cycle detection.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                                          | Direction
//  ---------+------------------------------------------------+----------
//  input    | s_valid s_ready s_action s_from_node s_to_node | in
//           | s_edge_weight                                  |
//  result   | m_valid m_ready m_status m_distance            | out
//  config   | cfg_valid cfg_ready cfg_data (node_count)      | in
//
//  An add transaction reads the list head, then writes the edge.
//  A clear transaction resets every list head, one list head reset per cycle;
//  the same pass runs after reset, during which no input is accepted.
//  A solve first reinitialises the node memory, then pops each dequeued node
//  and walks its edges, all bound by the single read port of the node
//  memory; the empty queue check, then the target read and the output load
//  end the solve.
//  A stalled result waits in the output register; the next input is only
//  taken once the solve has handed its result over.
// ----------------------------------------------------------------------------
module spfa_shortest_path_neg_cycle #(
    parameter int MAX_NODES = spfa_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = spfa_pkg::DEF_MAX_EDGES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_action,
    input  logic [spfa_pkg::NODE_W-1:0]         s_from_node,
    input  logic [spfa_pkg::NODE_W-1:0]         s_to_node,
    input  logic signed [spfa_pkg::WEIGHT_W-1:0] s_edge_weight,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic signed [spfa_pkg::DIST_W-1:0]  m_distance,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [spfa_pkg::COUNT_W-1:0]        cfg_data
);
    import spfa_pkg::*;

    // Node index width, edge index width and list pointer width (one extra
    // code, MAX_EDGES itself, marks the end of a list).
    localparam int NAW  = $clog2(MAX_NODES);
    localparam int EIW  = $clog2(MAX_EDGES);
    localparam int EAW  = $clog2(MAX_EDGES + 1);
    localparam int EDGE_W = NAW + WEIGHT_W + EAW;
    localparam int NODE_REC_W = $bits(node_t);

    localparam logic [EAW-1:0] NULL_EDGE = EAW'(MAX_EDGES);
    localparam logic [NAW-1:0] LAST_NODE = NAW'(MAX_NODES - 1);
    localparam logic [NAW:0]   FULL_Q    = (NAW+1)'(MAX_NODES);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_ADD, S_INIT, S_POP, S_POPW, S_UREAD,
        S_EDGE, S_EREAD, S_VREAD, S_FIN, S_DONE
    } state_t;

    state_t state_reg;

    logic [COUNT_W-1:0]      node_count_reg;
    logic [NAW-1:0]          sweep_reg;
    logic [EAW-1:0]          total_reg;
    logic [NODE_W-1:0]       from_reg;
    logic [NODE_W-1:0]       to_reg;
    logic [WEIGHT_W-1:0]     w_reg;
    logic [NAW-1:0]          qhead_reg;
    logic [NAW-1:0]          qtail_reg;
    logic [NAW:0]            used_reg;
    logic [NAW-1:0]          u_reg;
    logic [NAW-1:0]          v_reg;
    logic [DIST_W-1:0]       du_reg;
    logic [EAW-1:0]          e_reg;
    logic [WEIGHT_W-1:0]     cost_reg;
    logic [1:0]              res_status_reg;
    logic [DIST_W-1:0]       res_dist_reg;
    logic                    m_valid_reg;
    logic [1:0]              m_status_reg;
    logic [DIST_W-1:0]       m_distance_reg;

    // Memory ports.
    logic                  head_we;
    logic [NAW-1:0]        head_waddr, head_raddr;
    logic [EAW-1:0]        head_wdata, head_rdata;
    logic                  edge_we;
    logic [EIW-1:0]        edge_waddr, edge_raddr;
    logic [EDGE_W-1:0]     edge_wdata, edge_rdata;
    logic                  node_we;
    logic [NAW-1:0]        node_waddr, node_raddr;
    node_t                 node_wdata, node_rdata;
    logic [NODE_REC_W-1:0] node_rbits;
    logic                  q_we;
    logic [NAW-1:0]        q_waddr, q_raddr;
    logic [NAW-1:0]        q_wdata, q_rdata;

    spfa_ram #(.WIDTH(EAW), .DEPTH(MAX_NODES)) u_head_ram (
        .aclk(aclk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata)
    );
    spfa_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .aclk(aclk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
        .raddr(edge_raddr), .rdata(edge_rdata)
    );
    spfa_ram #(.WIDTH(NODE_REC_W), .DEPTH(MAX_NODES)) u_node_ram (
        .aclk(aclk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
        .raddr(node_raddr), .rdata(node_rbits)
    );
    spfa_ram #(.WIDTH(NAW), .DEPTH(MAX_NODES)) u_queue_ram (
        .aclk(aclk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    assign node_rdata = node_t'(node_rbits);

    logic s_fire;
    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_distance = m_distance_reg;

    // Edge record fields as read back.
    logic [NAW-1:0]      ed_dest;
    logic [WEIGHT_W-1:0] ed_cost;
    logic [EAW-1:0]      ed_link;
    assign {ed_dest, ed_cost, ed_link} = edge_rdata;

    // Relaxation of the current edge: a saturating candidate distance and the
    // decision whether it improves the destination.
    logic signed [DIST_W:0] sum;
    logic [DIST_W-1:0]      cand;
    logic                   improve;
    logic                   do_enq;
    logic [COUNT_W:0]       new_cnt;
    logic                   cycle_hit;

    always_comb begin
        sum = $signed({du_reg[DIST_W-1], du_reg})
            + $signed({{(DIST_W+1-WEIGHT_W){cost_reg[WEIGHT_W-1]}}, cost_reg});
        if (sum > $signed({DIST_MAX[DIST_W-1], DIST_MAX})) begin
            cand = DIST_MAX;
        end else if (sum < $signed({DIST_MIN[DIST_W-1], DIST_MIN})) begin
            cand = DIST_MIN;
        end else begin
            cand = sum[DIST_W-1:0];
        end
        improve   = !node_rdata.reached
                    || ($signed(cand) < $signed(node_rdata.path_len));
        do_enq    = improve && !node_rdata.inq && (used_reg < FULL_Q);
        new_cnt   = {1'b0, node_rdata.cnt} + 1'b1;
        cycle_hit = do_enq && (new_cnt > {1'b0, node_count_reg});
    end

    function automatic logic [NAW-1:0] wrap_inc(input logic [NAW-1:0] p);
        wrap_inc = (p == LAST_NODE) ? '0 : p + 1'b1;
    endfunction

    // Memory control.
    always_comb begin
        head_we    = 1'b0;
        head_waddr = sweep_reg;
        head_wdata = NULL_EDGE;
        head_raddr = NAW'(s_from_node);
        edge_we    = 1'b0;
        edge_waddr = total_reg[EIW-1:0];
        edge_wdata = {NAW'(to_reg), w_reg, head_rdata};
        edge_raddr = e_reg[EIW-1:0];
        node_we    = 1'b0;
        node_waddr = sweep_reg;
        node_wdata = '0;
        node_raddr = q_rdata;
        q_we       = 1'b0;
        q_waddr    = qtail_reg;
        q_wdata    = v_reg;
        q_raddr    = qhead_reg;
        unique case (state_reg)
            S_CLR: begin
                head_we = 1'b1;
            end
            S_ADD: begin
                if (total_reg != NULL_EDGE && 32'(from_reg) < MAX_NODES
                        && 32'(to_reg) < MAX_NODES) begin
                    edge_we    = 1'b1;
                    head_we    = 1'b1;
                    head_waddr = NAW'(from_reg);
                    head_wdata = total_reg;
                end
            end
            S_INIT: begin
                node_we = 1'b1;
                if (sweep_reg == NAW'(from_reg)) begin
                    node_wdata.reached = 1'b1;
                    node_wdata.inq     = 1'b1;
                    node_wdata.cnt     = COUNT_W'(1);
                end
                q_we    = 1'b1;
                q_waddr = '0;
                q_wdata = NAW'(from_reg);
            end
            S_POP: begin
                node_raddr = NAW'(to_reg);
            end
            S_POPW: begin
                head_raddr = q_rdata;
            end
            S_UREAD: begin
                node_we        = 1'b1;
                node_waddr     = u_reg;
                node_wdata     = node_rdata;
                node_wdata.inq = 1'b0;
            end
            S_EREAD: begin
                node_raddr = ed_dest;
            end
            S_VREAD: begin
                if (improve) begin
                    node_we             = 1'b1;
                    node_waddr          = v_reg;
                    node_wdata          = node_rdata;
                    node_wdata.path_len = cand;
                    node_wdata.reached  = 1'b1;
                    if (do_enq) begin
                        node_wdata.inq = 1'b1;
                        node_wdata.cnt = new_cnt[COUNT_W-1:0];
                        q_we           = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLR;
            sweep_reg      <= '0;
            total_reg      <= '0;
            node_count_reg <= NODE_COUNT_RESET;
            m_valid_reg    <= 1'b0;
            used_reg       <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                node_count_reg <= cfg_data;
            end
            // In S_DONE the output register is handled by the load below.
            if (m_valid_reg && m_ready && state_reg != S_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLR: begin
                    total_reg <= '0;
                    if (sweep_reg == LAST_NODE) begin
                        sweep_reg <= '0;
                        state_reg <= S_IDLE;
                    end else begin
                        sweep_reg <= sweep_reg + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (s_fire) begin
                        from_reg <= s_from_node;
                        to_reg   <= s_to_node;
                        w_reg    <= s_edge_weight;
                        sweep_reg <= '0;
                        priority case (s_action)
                            ACT_ADD:   state_reg <= S_ADD;
                            ACT_CLEAR: state_reg <= S_CLR;
                            ACT_SOLVE: begin
                                if (32'(s_from_node) < MAX_NODES) begin
                                    state_reg <= S_INIT;
                                end else begin
                                    res_status_reg <= ST_UNREACH;
                                    res_dist_reg   <= '0;
                                    state_reg      <= S_DONE;
                                end
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_ADD: begin
                    if (edge_we) begin
                        total_reg <= total_reg + 1'b1;
                    end
                    state_reg <= S_IDLE;
                end
                S_INIT: begin
                    qhead_reg <= '0;
                    qtail_reg <= wrap_inc('0);
                    used_reg  <= (NAW+1)'(1);
                    if (sweep_reg == LAST_NODE) begin
                        sweep_reg <= '0;
                        state_reg <= S_POP;
                    end else begin
                        sweep_reg <= sweep_reg + 1'b1;
                    end
                end
                S_POP: begin
                    state_reg <= (used_reg == '0) ? S_FIN : S_POPW;
                end
                S_POPW: begin
                    u_reg     <= q_rdata;
                    qhead_reg <= wrap_inc(qhead_reg);
                    used_reg  <= used_reg - 1'b1;
                    state_reg <= S_UREAD;
                end
                S_UREAD: begin
                    du_reg    <= node_rdata.path_len;
                    e_reg     <= head_rdata;
                    state_reg <= S_EDGE;
                end
                S_EDGE: begin
                    state_reg <= (e_reg == NULL_EDGE) ? S_POP : S_EREAD;
                end
                S_EREAD: begin
                    v_reg     <= ed_dest;
                    cost_reg  <= ed_cost;
                    e_reg     <= ed_link;
                    state_reg <= S_VREAD;
                end
                S_VREAD: begin
                    // A self loop changes the distance of the node being expanded.
                    if (improve && v_reg == u_reg) begin
                        du_reg <= cand;
                    end
                    if (do_enq) begin
                        qtail_reg <= wrap_inc(qtail_reg);
                        used_reg  <= used_reg + 1'b1;
                    end
                    if (cycle_hit) begin
                        res_status_reg <= ST_NEG_CYCLE;
                        res_dist_reg   <= '0;
                        state_reg      <= S_DONE;
                    end else begin
                        state_reg <= S_EDGE;
                    end
                end
                S_FIN: begin
                    if (32'(to_reg) < MAX_NODES && node_rdata.reached) begin
                        res_status_reg <= ST_OK;
                        res_dist_reg   <= node_rdata.path_len;
                    end else begin
                        res_status_reg <= ST_UNREACH;
                        res_dist_reg   <= '0;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg    <= 1'b1;
                        m_status_reg   <= res_status_reg;
                        m_distance_reg <= res_dist_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_CLR;
            endcase
        end
    end

    // The queue never holds more entries than there are nodes.
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= FULL_Q) else $error("work queue overfilled");

    // A dequeue is only started on a non-empty queue.
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_POPW |-> used_reg != '0) else $error("pop from empty queue");

    // The edge count never passes the capacity of the edge memory.
    a_edge_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= NULL_EDGE) else $error("edge count beyond capacity");

    // An input is only taken with the sequencer idle, and a solve result is
    // only loaded once the output register is free.
    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && m_valid_reg && !m_ready) |=> state_reg == S_DONE)
        else $error("result overwritten");

endmodule

// ===== rtl/spfa_ram.sv =====
// ----------------------------------------------------------------------------
// spfa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module spfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
